/* hdl/sliding_window_rate_shaper_unit_macros.svh */
// assertion macros for the sliding window rate shaper
// used at the end of the top level; no dependencies
`ifndef SLIDING_WINDOW_RATE_SHAPER_UNIT_MACROS_SVH
`define SLIDING_WINDOW_RATE_SHAPER_UNIT_MACROS_SVH

// same-cycle implication
`define SWRS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication does not hold");

// next-cycle implication
`define SWRS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication does not hold");

`endif

/* hdl/swrs_pkg.sv */
// shared types and constants for the sliding window rate shaper
// no dependencies
package swrs_pkg;

  localparam int CONN_COUNT_DEF   = 16;
  localparam int WINDOW_DEPTH_DEF = 256;

  localparam logic [29:0] OUT_MAX = 30'h3FFF_FFFF;
  localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;

  localparam logic [5:0] MAC_HDR_RESET  = 6'd6;
  localparam logic [3:0] FRAG_HDR_RESET = 4'd2;

  // configuration register indexes
  localparam logic CFG_MAC_HDR  = 1'b0;
  localparam logic CFG_FRAG_HDR = 1'b1;

  // item function codes
  localparam logic FUNC_QUERY  = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_FULL,
    RES_QUOTA
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     load;
    logic     push_def;
    logic     push_grant;
    logic     pop;
    logic     st_wr;
    logic     calc1;
    logic     calc2;
    logic     calc3;
    logic     res_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic func;
    logic known;
    logic full;
    logic pre_left;
    logic ring_empty;
    logic expired;
  } sts_t;

  typedef struct packed {
    logic [29:0] g;
    logic [29:0] c;
    logic [31:0] stamp;
  } rec_t;

endpackage

/* hdl/swrs_ctrl.sv */
// controller state machine for the rate shaper
// depends on swrs_pkg; drives swrs_dp through cmd_t and reads sts_t
module swrs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output swrs_pkg::cmd_t cmd,
  input  swrs_pkg::sts_t sts
);
  import swrs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_GET,
    S_DISPATCH,
    S_PREFILL,
    S_PUSH,
    S_EXP_RD,
    S_EXP_CHK,
    S_WB,
    S_CALC1,
    S_CALC2,
    S_CALC3,
    S_FIN
  } state_t;

  state_t   state;
  state_t   state_next;
  res_sel_t res_sel;
  res_sel_t res_sel_next;

  always_comb begin
    cmd          = '0;
    cmd.res_sel  = res_sel;
    state_next   = state;
    res_sel_next = res_sel;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: state_next = S_GET;
      S_GET: begin
        cmd.load   = 1'b1;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        res_sel_next = RES_ZERO;
        if (!sts.in_range) begin
          state_next = S_FIN;
        end else if (sts.func == FUNC_UPDATE) begin
          if (!sts.known) begin
            state_next = S_PREFILL;
          end else if (sts.full) begin
            res_sel_next = RES_FULL;
            state_next   = S_FIN;
          end else begin
            state_next = S_PUSH;
          end
        end else begin
          res_sel_next = RES_QUOTA;
          state_next   = sts.known ? S_EXP_RD : S_CALC1;
        end
      end
      S_PREFILL: begin
        if (sts.pre_left) begin
          cmd.push_def = 1'b1;
        end else begin
          cmd.push_grant = 1'b1;
          state_next     = S_WB;
        end
      end
      S_PUSH: begin
        cmd.push_grant = 1'b1;
        state_next     = S_WB;
      end
      // record at the ring head is read while here
      S_EXP_RD: state_next = sts.ring_empty ? S_WB : S_EXP_CHK;
      S_EXP_CHK: begin
        if (sts.expired) begin
          cmd.pop    = 1'b1;
          state_next = S_EXP_RD;
        end else begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        cmd.st_wr  = 1'b1;
        state_next = (sts.func == FUNC_UPDATE) ? S_FIN : S_CALC1;
      end
      S_CALC1: begin
        cmd.calc1  = 1'b1;
        state_next = S_CALC2;
      end
      S_CALC2: begin
        cmd.calc2  = 1'b1;
        state_next = S_CALC3;
      end
      S_CALC3: begin
        cmd.calc3  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.res_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      res_sel <= RES_ZERO;
      busy    <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      res_sel <= res_sel_next;
      busy    <= (state_next != S_IDLE);
      done    <= (state == S_FIN);
    end
  end

endmodule

/* hdl/swrs_dp.sv */
// datapath of the rate shaper: item registers, slot state, record ring memory, quota maths
// depends on swrs_pkg; commanded by swrs_ctrl
module swrs_dp #(
  parameter int CONN_COUNT   = swrs_pkg::CONN_COUNT_DEF,
  parameter int WINDOW_DEPTH = swrs_pkg::WINDOW_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  swrs_pkg::cmd_t cmd,
  output swrs_pkg::sts_t sts,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data,
  input  logic           func,
  input  logic [3:0]     conn_index,
  input  logic [31:0]    now_frame,
  input  logic [8:0]     window_frames,
  input  logic [23:0]    min_rate_bits,
  input  logic [23:0]    max_rate_bits,
  input  logic [31:0]    max_burst_bytes,
  input  logic [31:0]    queue_bytes,
  input  logic [15:0]    fragment_bytes,
  input  logic [29:0]    granted_guaranteed,
  input  logic [29:0]    granted_ceiling,
  output logic [29:0]    guaranteed_bytes,
  output logic [29:0]    ceiling_bytes,
  output logic           status
);
  import swrs_pkg::*;

  localparam int SW    = (CONN_COUNT > 1) ? $clog2(CONN_COUNT) : 1;
  localparam int PW    = $clog2(WINDOW_DEPTH);
  localparam int CNTW  = $clog2(WINDOW_DEPTH + 1);
  localparam int RECS  = CONN_COUNT * WINDOW_DEPTH;
  localparam int AW    = $clog2(RECS);
  localparam int POSW  = CNTW + 1;

  // configuration
  logic [5:0] mac_hdr;
  logic [3:0] frag_hdr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_hdr  <= MAC_HDR_RESET;
      frag_hdr <= FRAG_HDR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAC_HDR:  mac_hdr  <= cfg_data[5:0];
        CFG_FRAG_HDR: frag_hdr <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic          func_r;
  logic          in_range;
  logic [SW-1:0] slot;
  logic [31:0]   now_r;
  logic [8:0]    w_r;
  logic [23:0]   min_r;
  logic [23:0]   max_r;
  logic [31:0]   burst_r;
  logic [31:0]   queue_r;
  logic [15:0]   frag_r;
  logic [29:0]   gg_r;
  logic [29:0]   gc_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r   <= func;
      in_range <= ({28'd0, conn_index} < 32'(CONN_COUNT));
      slot     <= SW'(conn_index);
      now_r    <= now_frame;
      w_r      <= window_frames;
      min_r    <= min_rate_bits;
      max_r    <= max_rate_bits;
      burst_r  <= max_burst_bytes;
      queue_r  <= queue_bytes;
      frag_r   <= fragment_bytes;
      gg_r     <= granted_guaranteed;
      gc_r     <= granted_ceiling;
    end
  end

  // per-slot state: known bits in flops, the rest in a small memory
  logic [CONN_COUNT-1:0] conn_known;
  logic [31:0]           st_sg   [CONN_COUNT];
  logic [31:0]           st_sc   [CONN_COUNT];
  logic [PW-1:0]         st_head [CONN_COUNT];
  logic [CNTW-1:0]       st_cnt  [CONN_COUNT];
  logic [31:0]           st_sg_q;
  logic [31:0]           st_sc_q;
  logic [PW-1:0]         st_head_q;
  logic [CNTW-1:0]       st_cnt_q;

  logic [31:0]     sum_g;
  logic [31:0]     sum_c;
  logic [PW-1:0]   head;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] pre_cnt;
  logic            known;

  assign known = conn_known[slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      conn_known <= '0;
    end else if (cmd.st_wr && func_r == FUNC_UPDATE) begin
      conn_known[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.st_wr) begin
      st_sg[slot]   <= sum_g;
      st_sc[slot]   <= sum_c;
      st_head[slot] <= head;
      st_cnt[slot]  <= count;
    end
    st_sg_q   <= st_sg[slot];
    st_sc_q   <= st_sc[slot];
    st_head_q <= st_head[slot];
    st_cnt_q  <= st_cnt[slot];
  end

  // record ring memory
  rec_t          rec_mem [RECS];
  rec_t          rec_q;
  rec_t          rec_wr;
  logic [AW-1:0] base;
  logic [POSW-1:0] pos_sum;
  logic [PW-1:0] pos;
  logic          push;

  assign base    = AW'(slot) * AW'(WINDOW_DEPTH);
  assign pos_sum = POSW'(head) + POSW'(count);
  assign pos     = (pos_sum >= POSW'(WINDOW_DEPTH)) ? PW'(pos_sum - POSW'(WINDOW_DEPTH))
                                                    : PW'(pos_sum);
  assign push    = cmd.push_def || cmd.push_grant;

  // one-frame defaults, ceiling not below guaranteed
  logic [21:0] dg;
  logic [20:0] dc;
  logic [29:0] dc_fix;

  assign dg     = 22'((25'(min_r) + 25'd7) >> 3);
  assign dc     = max_r[23:3];
  assign dc_fix = ({9'd0, dc} < {8'd0, dg}) ? {8'd0, dg} : {9'd0, dc};

  always_comb begin
    if (cmd.push_def) begin
      rec_wr.g     = {8'd0, dg};
      rec_wr.c     = dc_fix;
      rec_wr.stamp = now_r - 32'(pre_cnt);
    end else begin
      rec_wr.g     = gg_r;
      rec_wr.c     = gc_r;
      rec_wr.stamp = now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rec_mem[base + AW'(pos)] <= rec_wr;
    end
    rec_q <= rec_mem[base + AW'(head)];
  end

  // window threshold and prefill length
  logic [8:0]  thr;
  logic [12:0] k_raw;
  logic [32:0] add_g;
  logic [32:0] add_c;

  assign thr   = (w_r == 9'd0) ? 9'd0 : w_r - 9'd1;
  assign k_raw = (13'(thr) > 13'(WINDOW_DEPTH - 1)) ? 13'(WINDOW_DEPTH - 1) : 13'(thr);
  assign add_g = {1'b0, sum_g} + 33'(rec_wr.g);
  assign add_c = {1'b0, sum_c} + 33'(rec_wr.c);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (known) begin
        sum_g <= st_sg_q;
        sum_c <= st_sc_q;
        head  <= st_head_q;
        count <= st_cnt_q;
      end else begin
        sum_g <= '0;
        sum_c <= '0;
        head  <= '0;
        count <= '0;
      end
      pre_cnt <= CNTW'(k_raw);
    end else if (push) begin
      sum_g <= add_g[32] ? SUM_MAX : add_g[31:0];
      sum_c <= add_c[32] ? SUM_MAX : add_c[31:0];
      count <= count + CNTW'(1);
      if (cmd.push_def) begin
        pre_cnt <= pre_cnt - CNTW'(1);
      end
    end else if (cmd.pop) begin
      sum_g <= (sum_g > 32'(rec_q.g)) ? sum_g - 32'(rec_q.g) : 32'd0;
      sum_c <= (sum_c > 32'(rec_q.c)) ? sum_c - 32'(rec_q.c) : 32'd0;
      head  <= (head == PW'(WINDOW_DEPTH - 1)) ? '0 : head + PW'(1);
      count <= count - CNTW'(1);
    end
  end

  assign sts.in_range   = in_range;
  assign sts.func       = func_r;
  assign sts.known      = known;
  assign sts.full       = (count >= CNTW'(WINDOW_DEPTH));
  assign sts.pre_left   = (pre_cnt != '0);
  assign sts.ring_empty = (count == '0);
  assign sts.expired    = ((now_r - rec_q.stamp) >= {23'd0, thr});

  // quota pipeline
  logic [30:0] pg;
  logic [30:0] pc;
  logic [30:0] qg;
  logic [30:0] qc;
  logic [31:0] queue_eff;
  logic [31:0] cap;
  logic [33:0] prod_g;
  logic [33:0] prod_c;
  logic [6:0]  hdr;
  logic [15:0] ovh;

  assign prod_g = 34'(w_r) * 34'(min_r) + 34'd7;
  assign prod_c = 34'(w_r) * 34'(max_r);
  assign hdr    = 7'(mac_hdr) + 7'(frag_hdr);
  assign ovh    = (frag_r > 16'(hdr)) ? frag_r - 16'(hdr) : 16'd0;

  always_ff @(posedge clk) begin
    if (cmd.calc1) begin
      if (known) begin
        pg <= prod_g[33:3];
        pc <= prod_c[33:3];
      end else begin
        pg <= 31'(dg);
        pc <= 31'(dc);
      end
      queue_eff <= (queue_r > 32'(ovh)) ? queue_r - 32'(ovh) : 32'd0;
    end
    if (cmd.calc2) begin
      if (known) begin
        qg <= (32'(pg) > sum_g) ? 31'(32'(pg) - sum_g) : 31'd0;
        qc <= (32'(pc) > sum_c) ? 31'(32'(pc) - sum_c) : 31'd0;
      end else begin
        qg <= pg;
        qc <= pc;
      end
    end
    if (cmd.calc3) begin
      if (qc < qg) begin
        qc <= qg;
      end
      cap <= (burst_r < queue_eff) ? burst_r : queue_eff;
    end
  end

  // final caps and result registers
  logic [31:0] fg;
  logic [31:0] fc;

  assign fg = (32'(qg) < cap) ? 32'(qg) : cap;
  assign fc = (32'(qc) < cap) ? 32'(qc) : cap;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_QUOTA: begin
          guaranteed_bytes <= (fg > 32'(OUT_MAX)) ? OUT_MAX : fg[29:0];
          ceiling_bytes    <= (fc > 32'(OUT_MAX)) ? OUT_MAX : fc[29:0];
          status           <= 1'b0;
        end
        RES_FULL: begin
          guaranteed_bytes <= '0;
          ceiling_bytes    <= '0;
          status           <= 1'b1;
        end
        default: begin
          guaranteed_bytes <= '0;
          ceiling_bytes    <= '0;
          status           <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* hdl/sliding_window_rate_shaper_unit.sv */
// Sliding window rate shaper. An item is taken when start is high and busy is low; its single
// result appears on guaranteed_bytes, ceiling_bytes and status with done high for one cycle,
// and the receiver cannot stall it. Items are handled one at a time by a state machine over a
// record ring memory with one write and one read port. An update loads the slot state, pushes
// its record and writes the state back, after first pushing prefilled default records on
// the first update of a connection (up to WINDOW_DEPTH - 1). An update on a full ring is
// dropped. A query of an unknown connection goes straight to the quota maths; a query of a known
// one first pops each expired record from the ring head. No clearing pass is needed after reset.
// Depends on swrs_pkg, swrs_ctrl, swrs_dp and the assertion macros header.
`include "sliding_window_rate_shaper_unit_macros.svh"

module sliding_window_rate_shaper_unit #(
  parameter int CONN_COUNT   = swrs_pkg::CONN_COUNT_DEF,
  parameter int WINDOW_DEPTH = swrs_pkg::WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        func,
  input  logic [3:0]  conn_index,
  input  logic [31:0] now_frame,
  input  logic [8:0]  window_frames,
  input  logic [23:0] min_rate_bits,
  input  logic [23:0] max_rate_bits,
  input  logic [31:0] max_burst_bytes,
  input  logic [31:0] queue_bytes,
  input  logic [15:0] fragment_bytes,
  input  logic [29:0] granted_guaranteed,
  input  logic [29:0] granted_ceiling,
  output logic [29:0] guaranteed_bytes,
  output logic [29:0] ceiling_bytes,
  output logic        status
);
  import swrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  swrs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  swrs_dp #(
    .CONN_COUNT   (CONN_COUNT),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .func               (func),
    .conn_index         (conn_index),
    .now_frame          (now_frame),
    .window_frames      (window_frames),
    .min_rate_bits      (min_rate_bits),
    .max_rate_bits      (max_rate_bits),
    .max_burst_bytes    (max_burst_bytes),
    .queue_bytes        (queue_bytes),
    .fragment_bytes     (fragment_bytes),
    .granted_guaranteed (granted_guaranteed),
    .granted_ceiling    (granted_ceiling),
    .guaranteed_bytes   (guaranteed_bytes),
    .ceiling_bytes      (ceiling_bytes),
    .status             (status)
  );

  // a result closes its item, so the block is free again
  `SWRS_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy)
  // an accepted item keeps the block busy in the next cycle
  `SWRS_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  // a dropped update reports no allowance
  `SWRS_ASSERT_IMP(a_full_zero, clk, rst, done && status,
                   guaranteed_bytes == '0 && ceiling_bytes == '0)
  // one result per item
  `SWRS_ASSERT_NXT(a_done_single, clk, rst, done, !done)

endmodule
